// ===== sv/stc_pkg.sv =====
// Shared types and constants of the span timer with loop modes.
package stc_pkg;

   // Width of the shared adder; holds any 64-bit operand sum exactly.
   localparam int ALU_W = 66;

   // Default width of the stored time.
   localparam int TIME_WIDTH_DEF = 32;

   // Play modes.
   localparam logic [2:0] MODE_NORMAL   = 3'd0;
   localparam logic [2:0] MODE_REVERSE  = 3'd1;
   localparam logic [2:0] MODE_CONT     = 3'd2;
   localparam logic [2:0] MODE_CONT_REV = 3'd3;
   localparam logic [2:0] MODE_LOOP     = 3'd4;
   localparam logic [2:0] MODE_LOOP_REV = 3'd5;
   localparam logic [2:0] MODE_PING     = 3'd6;

   // Configuration register indexes.
   localparam logic [1:0] REG_PLAY_MODE  = 2'd0;
   localparam logic [1:0] REG_SPAN_START = 2'd1;
   localparam logic [1:0] REG_SPAN_END   = 2'd2;
   localparam logic [1:0] REG_SPEED      = 2'd3;

   // Reset values of the configuration registers.
   localparam logic [2:0]        RST_PLAY_MODE  = MODE_NORMAL;
   localparam logic signed [31:0] RST_SPAN_START = 32'sd0;
   localparam logic signed [31:0] RST_SPAN_END   = 32'sd65536;
   localparam logic signed [15:0] RST_SPEED      = 16'sd256;

   typedef struct packed {
      logic [2:0]         play_mode;
      logic signed [31:0] span_start;
      logic signed [31:0] span_end;
      logic signed [15:0] speed;
   } cfg_type;

   typedef struct packed {
      logic       valid;
      logic [2:0] mode;
   } mode_wr_type;

   typedef struct packed {
      logic signed [ALU_W-1:0] a;
      logic signed [ALU_W-1:0] b;
      logic                    sub;
   } alu_req_type;

   typedef struct packed {
      logic signed [31:0] time_now;
      logic signed [31:0] reported_time;
      logic signed [15:0] cycle_count;
      logic [15:0]        spans_completed;
      logic [15:0]        wraps_in_step;
      logic               stopped;
      logic               moving_backward;
   } result_type;

endpackage

// ===== sv/stc_alu.sv =====
// Shared adder and subtractor with a saturated 64-bit view of the result.
module stc_alu import stc_pkg::*; (
   input  alu_req_type             req,
   output logic signed [ALU_W-1:0] sum,
   output logic signed [63:0]      sum_sat
);

   localparam logic signed [ALU_W-1:0] HI64 = {{(ALU_W-63){1'b0}}, {63{1'b1}}};
   localparam logic signed [ALU_W-1:0] LO64 = {{(ALU_W-63){1'b1}}, {63{1'b0}}};

   logic signed [ALU_W-1:0] b_eff;

   assign b_eff = req.sub ? ~req.b : req.b;
   assign sum   = req.a + b_eff + {{(ALU_W-1){1'b0}}, req.sub};

   always_comb begin
      if (sum > HI64) begin
         sum_sat = HI64[63:0];
      end else if (sum < LO64) begin
         sum_sat = LO64[63:0];
      end else begin
         sum_sat = sum[63:0];
      end
   end

endmodule

// ===== sv/stc_core.sv =====
// Sequencer and state of the span timer; the multiply, divide and time arithmetic goes through one shared adder.
module stc_core import stc_pkg::*; #(
   parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  mode_wr_type mode_wr,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic        in_action,
   input  logic [31:0] in_step,
   output logic        out_valid,
   input  logic        out_take,
   output result_type  out_result
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_LEN   = 4'd1;
   localparam logic [3:0] ST_MUL   = 4'd2;
   localparam logic [3:0] ST_ADD   = 4'd3;
   localparam logic [3:0] ST_CMP   = 4'd4;
   localparam logic [3:0] ST_PP    = 4'd5;
   localparam logic [3:0] ST_DIV   = 4'd6;
   localparam logic [3:0] ST_POS   = 4'd7;
   localparam logic [3:0] ST_BASE  = 4'd8;
   localparam logic [3:0] ST_PLACE = 4'd9;
   localparam logic [3:0] ST_RBEG  = 4'd10;
   localparam logic [3:0] ST_RMUL  = 4'd11;
   localparam logic [3:0] ST_RNEG  = 4'd12;
   localparam logic [3:0] ST_DONE  = 4'd13;

   localparam logic [3:0] MUL_LAST = 4'd15;
   localparam logic [5:0] DIV_LAST = 6'd63;

   localparam logic [1:0] WSEL_P1 = 2'd0;
   localparam logic [1:0] WSEL_0  = 2'd1;
   localparam logic [1:0] WSEL_M1 = 2'd2;

   localparam logic signed [ALU_W-1:0] TW_HI =
      {{(ALU_W-TIME_WIDTH+1){1'b0}}, {(TIME_WIDTH-1){1'b1}}};
   localparam logic signed [ALU_W-1:0] TW_LO =
      {{(ALU_W-TIME_WIDTH+1){1'b1}}, {(TIME_WIDTH-1){1'b0}}};
   localparam logic signed [ALU_W-1:0] HI32 = {{(ALU_W-31){1'b0}}, {31{1'b1}}};
   localparam logic signed [ALU_W-1:0] LO32 = {{(ALU_W-31){1'b1}}, {31{1'b0}}};

   function automatic logic signed [TIME_WIDTH-1:0] clamp_tw(
      input logic signed [ALU_W-1:0] v);
      if (v > TW_HI) begin
         clamp_tw = TW_HI[TIME_WIDTH-1:0];
      end else if (v < TW_LO) begin
         clamp_tw = TW_LO[TIME_WIDTH-1:0];
      end else begin
         clamp_tw = v[TIME_WIDTH-1:0];
      end
   endfunction

   function automatic logic signed [31:0] clamp32(input logic signed [ALU_W-1:0] v);
      if (v > HI32) begin
         clamp32 = HI32[31:0];
      end else if (v < LO32) begin
         clamp32 = LO32[31:0];
      end else begin
         clamp32 = v[31:0];
      end
   endfunction

   function automatic logic signed [ALU_W-1:0] sx32(input logic signed [31:0] v);
      sx32 = {{(ALU_W-32){v[31]}}, v};
   endfunction

   function automatic logic [15:0] sat_spans(input logic [15:0] s, input logic [15:0] n);
      logic [16:0] t;
      t = {1'b0, s} + {1'b0, n};
      sat_spans = t[16] ? 16'hFFFF : t[15:0];
   endfunction

   function automatic logic signed [15:0] sat_cyc(input logic signed [15:0] c,
                                                 input logic [15:0] n,
                                                 input logic down);
      logic signed [17:0] v;
      v = down ? ({{2{c[15]}}, c} - {2'b00, n}) : ({{2{c[15]}}, c} + {2'b00, n});
      if (v > 18'sd32767) begin
         sat_cyc = 16'sh7FFF;
      end else if (v < -18'sd32768) begin
         sat_cyc = 16'sh8000;
      end else begin
         sat_cyc = v[15:0];
      end
   endfunction

   logic [3:0]                   st_ff, st_in;
   logic [5:0]                   cnt_ff, cnt_in;
   logic signed [TIME_WIDTH-1:0] cur_ff, cur_in;
   logic signed [15:0]           cyc_ff, cyc_in;
   logic                         dneg_ff, dneg_in;
   logic [15:0]                  spans_ff, spans_in;
   logic                         run_ff, run_in;
   logic                         act_ff, act_in;
   logic [31:0]                  step_ff, step_in;
   logic signed [32:0]           len_ff, len_in;
   logic signed [ALU_W-1:0]      acc_ff, acc_in;
   logic signed [63:0]           t_ff, t_in;
   logic [63:0]                  dvd_ff, dvd_in;
   logic [32:0]                  rem_ff, rem_in;
   logic [31:0]                  pos_ff, pos_in;
   logic                         usgn_ff, usgn_in;
   logic [15:0]                  wsat_ff, wsat_in;
   logic signed [31:0]           rep_ff, rep_in;

   alu_req_type             alu_req;
   logic signed [ALU_W-1:0] alu_sum;
   logic signed [63:0]      alu_sat;

   logic signed [ALU_W-1:0] cur_x;
   logic signed [ALU_W-1:0] t_x;
   logic signed [ALU_W-1:0] len_x;
   logic [15:0]             spd_mag;
   logic [15:0]             cyc_mag;
   logic                    step_neg;
   logic                    mul_bit;
   logic                    rmul_bit;
   logic [32:0]             rem_sh;
   logic                    qhi;
   logic [15:0]             q16;
   logic                    rnz;
   logic [1:0]              wsel;
   logic [15:0]             wsat_n;
   logic                    wodd_n;
   logic                    cont_mode;

   stc_alu u_alu (
      .req     (alu_req),
      .sum     (alu_sum),
      .sum_sat (alu_sat)
   );

   assign cur_x     = {{(ALU_W-TIME_WIDTH){cur_ff[TIME_WIDTH-1]}}, cur_ff};
   assign t_x       = {{(ALU_W-64){t_ff[63]}}, t_ff};
   assign len_x     = {{(ALU_W-33){len_ff[32]}}, len_ff};
   assign spd_mag   = cfg.speed[15] ? 16'(-cfg.speed) : cfg.speed;
   assign cyc_mag   = cyc_ff[15] ? 16'(-cyc_ff) : cyc_ff;
   assign step_neg  = cfg.speed[15] ^ dneg_ff;
   assign mul_bit   = spd_mag[MUL_LAST - cnt_ff[3:0]];
   assign rmul_bit  = cyc_mag[MUL_LAST - cnt_ff[3:0]];
   assign rem_sh    = {rem_ff[31:0], dvd_ff[63]};
   assign qhi       = |dvd_ff[63:16];
   assign q16       = dvd_ff[15:0];
   assign rnz       = |rem_ff[31:0];
   assign cont_mode = (cfg.play_mode == MODE_CONT) || (cfg.play_mode == MODE_CONT_REV);

   // Wrap count of the finished division, saturated, and its parity.
   always_comb begin
      if (cfg.play_mode != MODE_PING) begin
         wsel = WSEL_P1;
      end else if (!usgn_ff) begin
         wsel = rnz ? WSEL_0 : WSEL_M1;
      end else begin
         wsel = rnz ? WSEL_P1 : WSEL_0;
      end
      case (wsel)
         WSEL_P1: begin
            wsat_n = (qhi || (&q16)) ? 16'hFFFF : q16 + 16'd1;
            wodd_n = ~dvd_ff[0];
         end
         WSEL_0: begin
            wsat_n = qhi ? 16'hFFFF : q16;
            wodd_n = dvd_ff[0];
         end
         default: begin
            // A single reflection that lands exactly on the end still counts once.
            if (!qhi && (q16 == 16'd1)) begin
               wsat_n = 16'd1;
               wodd_n = 1'b1;
            end else begin
               wsat_n = qhi ? 16'hFFFF : q16 - 16'd1;
               wodd_n = ~dvd_ff[0];
            end
         end
      endcase
   end

   always_comb begin
      st_in    = st_ff;
      cnt_in   = cnt_ff;
      cur_in   = cur_ff;
      cyc_in   = cyc_ff;
      dneg_in  = dneg_ff;
      spans_in = spans_ff;
      run_in   = run_ff;
      act_in   = act_ff;
      step_in  = step_ff;
      len_in   = len_ff;
      acc_in   = acc_ff;
      t_in     = t_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      pos_in   = pos_ff;
      usgn_in  = usgn_ff;
      wsat_in  = wsat_ff;
      rep_in   = rep_ff;
      alu_req  = '0;

      case (st_ff)
         ST_IDLE: begin
            if (in_valid) begin
               act_in  = in_action;
               step_in = in_step;
               st_in   = ST_LEN;
            end
         end
         ST_LEN: begin
            alu_req.a   = sx32(cfg.span_end);
            alu_req.b   = sx32(cfg.span_start);
            alu_req.sub = 1'b1;
            len_in      = alu_sum[32:0];
            wsat_in     = '0;
            acc_in      = '0;
            cnt_in      = '0;
            st_in       = ST_RBEG;
            if (!act_ff) begin
               cur_in   = clamp_tw(sx32(dneg_ff ? cfg.span_end : cfg.span_start));
               cyc_in   = '0;
               spans_in = '0;
               run_in   = 1'b1;
            end else if (run_ff && (step_ff != '0)) begin
               if (alu_sum[ALU_W-1] || (alu_sum == '0)) begin
                  run_in = 1'b0;
               end else begin
                  st_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            alu_req.a = {acc_ff[ALU_W-2:0], 1'b0};
            alu_req.b = mul_bit ? {{(ALU_W-32){1'b0}}, step_ff} : '0;
            acc_in    = alu_sum;
            cnt_in    = cnt_ff + 6'd1;
            if (cnt_ff[3:0] == MUL_LAST) begin
               st_in = ST_ADD;
            end
         end
         ST_ADD: begin
            alu_req.a   = cur_x;
            alu_req.b   = {{(ALU_W-40){1'b0}}, acc_ff[47:8]};
            alu_req.sub = step_neg;
            t_in        = alu_sat;
            st_in       = ST_CMP;
         end
         ST_CMP: begin
            alu_req.sub = 1'b1;
            rem_in      = '0;
            cnt_in      = '0;
            st_in       = ST_PLACE;
            case (cfg.play_mode)
               MODE_NORMAL: begin
                  alu_req.a = t_x;
                  alu_req.b = sx32(cfg.span_end);
                  if (!alu_sum[ALU_W-1]) begin
                     t_in     = {{32{cfg.span_end[31]}}, cfg.span_end};
                     cyc_in   = 16'sd1;
                     spans_in = sat_spans(spans_ff, 16'd1);
                     run_in   = 1'b0;
                  end
               end
               MODE_REVERSE: begin
                  alu_req.a = t_x;
                  alu_req.b = sx32(cfg.span_start);
                  if (alu_sum[ALU_W-1]) begin
                     t_in     = {{32{cfg.span_start[31]}}, cfg.span_start};
                     cyc_in   = -16'sd1;
                     spans_in = sat_spans(spans_ff, 16'd1);
                     run_in   = 1'b0;
                  end
               end
               MODE_CONT, MODE_LOOP: begin
                  alu_req.a = t_x;
                  alu_req.b = sx32(cfg.span_end);
                  dvd_in    = alu_sat;
                  if (!alu_sum[ALU_W-1]) begin
                     st_in = ST_DIV;
                  end
               end
               MODE_CONT_REV, MODE_LOOP_REV: begin
                  alu_req.a = sx32(cfg.span_start);
                  alu_req.b = t_x;
                  dvd_in    = alu_sat;
                  if (!alu_sum[ALU_W-1]) begin
                     st_in = ST_DIV;
                  end
               end
               MODE_PING: begin
                  alu_req.a = t_x;
                  alu_req.b = sx32(cfg.span_start);
                  dvd_in    = alu_sat;
                  usgn_in   = alu_sum[ALU_W-1];
                  st_in     = ST_PP;
               end
               default: begin
                  st_in = ST_PLACE;
               end
            endcase
         end
         ST_PP: begin
            // Inside the span nothing happens; below it the distance is negated.
            alu_req.sub = 1'b1;
            if (usgn_ff) begin
               alu_req.a = '0;
               alu_req.b = {{(ALU_W-64){dvd_ff[63]}}, dvd_ff};
               dvd_in    = alu_sum[63:0];
               st_in     = ST_DIV;
            end else begin
               alu_req.a = {{(ALU_W-64){dvd_ff[63]}}, dvd_ff};
               alu_req.b = len_x;
               st_in     = alu_sum[ALU_W-1] ? ST_PLACE : ST_DIV;
            end
         end
         ST_DIV: begin
            alu_req.a   = {{(ALU_W-33){1'b0}}, rem_sh};
            alu_req.b   = len_x;
            alu_req.sub = 1'b1;
            rem_in      = alu_sum[ALU_W-1] ? rem_sh : alu_sum[32:0];
            dvd_in      = {dvd_ff[62:0], ~alu_sum[ALU_W-1]};
            cnt_in      = cnt_ff + 6'd1;
            if (cnt_ff == DIV_LAST) begin
               st_in = ST_POS;
            end
         end
         ST_POS: begin
            alu_req.a   = len_x;
            alu_req.b   = {{(ALU_W-32){1'b0}}, rem_ff[31:0]};
            alu_req.sub = 1'b1;
            wsat_in     = wsat_n;
            spans_in    = sat_spans(spans_ff, wsat_n);
            pos_in      = rem_ff[31:0];
            if (cfg.play_mode == MODE_CONT) begin
               cyc_in = sat_cyc(cyc_ff, wsat_n, 1'b0);
            end else if (cfg.play_mode == MODE_CONT_REV) begin
               cyc_in = sat_cyc(cyc_ff, wsat_n, 1'b1);
            end else if (cfg.play_mode == MODE_PING) begin
               if (wodd_n) begin
                  dneg_in = ~dneg_ff;
               end
               if (rnz) begin
                  pos_in = dvd_ff[0] ? alu_sum[31:0] : rem_ff[31:0];
               end else begin
                  pos_in = dvd_ff[0] ? len_ff[31:0] : '0;
               end
            end
            st_in = ST_BASE;
         end
         ST_BASE: begin
            if ((cfg.play_mode == MODE_CONT_REV) || (cfg.play_mode == MODE_LOOP_REV)) begin
               alu_req.a   = sx32(cfg.span_end);
               alu_req.sub = 1'b1;
            end else begin
               alu_req.a = sx32(cfg.span_start);
            end
            alu_req.b = {{(ALU_W-32){1'b0}}, pos_ff};
            t_in      = alu_sum[63:0];
            st_in     = ST_PLACE;
         end
         ST_PLACE: begin
            cur_in = clamp_tw(t_x);
            acc_in = '0;
            cnt_in = '0;
            st_in  = ST_RBEG;
         end
         ST_RBEG: begin
            if (cont_mode) begin
               st_in = ST_RMUL;
            end else begin
               rep_in = clamp32(cur_x);
               st_in  = ST_DONE;
            end
         end
         ST_RMUL: begin
            alu_req.a = {acc_ff[ALU_W-2:0], 1'b0};
            alu_req.b = rmul_bit ? len_x : '0;
            acc_in    = alu_sum;
            cnt_in    = cnt_ff + 6'd1;
            if (cnt_ff[3:0] == MUL_LAST) begin
               st_in = ST_RNEG;
            end
         end
         ST_RNEG: begin
            alu_req.a   = cur_x;
            alu_req.b   = acc_ff;
            alu_req.sub = cyc_ff[15];
            rep_in      = clamp32(alu_sum);
            st_in       = ST_DONE;
         end
         ST_DONE: begin
            if (out_take) begin
               st_in = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase

      // A play mode write sets the direction; the user must issue it only while idle, the core does not enforce this.
      if (mode_wr.valid) begin
         dneg_in = mode_wr.mode inside {MODE_REVERSE, MODE_CONT_REV, MODE_LOOP_REV};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= ST_IDLE;
         cnt_ff   <= '0;
         cur_ff   <= '0;
         cyc_ff   <= '0;
         dneg_ff  <= 1'b0;
         spans_ff <= '0;
         run_ff   <= 1'b0;
      end else begin
         st_ff    <= st_in;
         cnt_ff   <= cnt_in;
         cur_ff   <= cur_in;
         cyc_ff   <= cyc_in;
         dneg_ff  <= dneg_in;
         spans_ff <= spans_in;
         run_ff   <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff  <= act_in;
      step_ff <= step_in;
      len_ff  <= len_in;
      acc_ff  <= acc_in;
      t_ff    <= t_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      pos_ff  <= pos_in;
      usgn_ff <= usgn_in;
      wsat_ff <= wsat_in;
      rep_ff  <= rep_in;
   end

   assign in_ready  = (st_ff == ST_IDLE);
   assign out_valid = (st_ff == ST_DONE);

   assign out_result.time_now        = clamp32(cur_x);
   assign out_result.reported_time   = rep_ff;
   assign out_result.cycle_count     = cyc_ff;
   assign out_result.spans_completed = spans_ff;
   assign out_result.wraps_in_step   = wsat_ff;
   assign out_result.stopped         = ~run_ff;
   assign out_result.moving_backward = dneg_ff;

endmodule

// ===== sv/span_timer_with_loop_modes_unit.sv =====
// Top level of the span timer with loop modes: ports, configuration registers, result register.
//
//   Channel   Direction  Handshake              Carries
//   req_*     in         req_tvalid/req_tready  one request: start or advance by a step
//   rsp_*     out        rsp_tvalid/rsp_tready  one result per request
//   csr_*     in         csr_valid/csr_ready    configuration register writes
//
// A request runs through a sequencer that drives a single 66-bit adder. A start request
// puts the time on its starting edge; an advance scales the step by the speed in a
// shift-add loop, and a wrap or reflection adds a bit-serial division on the same adder.
// Continue modes add a shift-add product for the reported time. Reset is synchronous and
// clears the timer state and the configuration registers. The result register decouples
// the sides: a new request is accepted while a finished result still waits on a stalled
// rsp_tready.
module span_timer_with_loop_modes_unit import stc_pkg::*; #(
   parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   // Request channel.
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // [31:0] step_delta
   input  logic         req_tuser,   // [0] action: 0 start, 1 advance
   // Result channel.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [119:0] rsp_tdata,   // [31:0] time_now, [63:32] reported_time,
                                     // [79:64] cycle_count, [95:80] spans_completed,
                                     // [111:96] wraps_in_step, [112] stopped,
                                     // [113] moving_backward, [119:114] zero
   // Configuration write channel.
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   cfg_type     cfg_ff, cfg_in;
   mode_wr_type mode_wr;
   logic        csr_write;

   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_data_ff, rsp_data_in;

   logic        core_in_ready;
   logic        core_out_valid;
   logic        core_take;
   result_type  core_result;

   // Always writable; the user must issue writes only while the timer is idle; not enforced.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_PLAY_MODE:  cfg_in.play_mode  = csr_wdata[2:0];
            REG_SPAN_START: cfg_in.span_start = csr_wdata;
            REG_SPAN_END:   cfg_in.span_end   = csr_wdata;
            REG_SPEED:      cfg_in.speed      = csr_wdata[15:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   // The direction flag lives in the core and follows every play mode write.
   assign mode_wr.valid = csr_write && (csr_index == REG_PLAY_MODE);
   assign mode_wr.mode  = csr_wdata[2:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.play_mode  <= RST_PLAY_MODE;
         cfg_ff.span_start <= RST_SPAN_START;
         cfg_ff.span_end   <= RST_SPAN_END;
         cfg_ff.speed      <= RST_SPEED;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   stc_core #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .mode_wr    (mode_wr),
      .in_valid   (req_tvalid),
      .in_ready   (core_in_ready),
      .in_action  (req_tuser),
      .in_step    (req_tdata),
      .out_valid  (core_out_valid),
      .out_take   (core_take),
      .out_result (core_result)
   );

   assign req_tready = core_in_ready;

   // The core hands its result over as soon as the result register is free or drains.
   assign core_take = core_out_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (core_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = core_result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0,
                        rsp_data_ff.moving_backward,
                        rsp_data_ff.stopped,
                        rsp_data_ff.wraps_in_step,
                        rsp_data_ff.spans_completed,
                        rsp_data_ff.cycle_count,
                        rsp_data_ff.reported_time,
                        rsp_data_ff.time_now};

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench of the span timer with loop modes: stream driver, monitor and predictor.
`timescale 1ns / 100ps

module tb_top;
   import stc_pkg::*;

   // Action codes carried in req_tuser.
   localparam logic ACT_START   = 1'b0;
   localparam logic ACT_ADVANCE = 1'b1;

   // Limits of the stored time and of the 32-bit span registers.
   localparam longint SPAN_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam longint SPAN_MIN = -64'sh0000_0000_8000_0000;

   // The cycle limit lies far beyond the slowest correct run.
   localparam int CYCLE_LIMIT = 1_500_000;

   // One queued stimulus operation: either a register write or a timer request.
   // The idling percentages travel with it so that each phase keeps its own traffic shape.
   typedef struct {
      bit          is_csr;
      logic [1:0]  idx;
      logic [31:0] wdata;
      logic        act;
      logic [31:0] delta;
      int          gap_pct;
      int          stall_pct;
   } stim_op_t;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [31:0]  req_tdata = '0;   // [31:0] step_delta
   logic         req_tuser = 1'b0; // [0] action: 0 start, 1 advance
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [119:0] rsp_tdata;        // [31:0] time_now, [63:32] reported_time,
                                   // [79:64] cycle_count, [95:80] spans_completed,
                                   // [111:96] wraps_in_step, [112] stopped,
                                   // [113] moving_backward, [119:114] zero
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [1:0]   csr_index = '0;
   logic [31:0]  csr_wdata = '0;

   stim_op_t   stim_q[$];
   result_type due_results[$];
   int         mismatches = 0;
   int         cycles = 0;
   int         gap_set = 0;
   int         stall_set = 0;
   int         stall_now = 0;
   bit         req_hit = 1'b0;
   bit         csr_hit = 1'b0;

   // Predictor copy of the configuration registers, at their reset values.
   logic [2:0] cf_mode  = MODE_NORMAL;
   longint     cf_start = 0;
   longint     cf_end   = 65536;
   longint     cf_speed = 256;

   // Predictor copy of the timer state, at its reset values.
   longint     tm_time   = 0;
   int         tm_cycles = 0;
   bit         tm_back   = 1'b0;
   int         tm_spans  = 0;
   bit         tm_run    = 1'b0;

   span_timer_with_loop_modes_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Saturate a wide time value to the signed 32-bit range of the outputs.
   function automatic longint sat32(input longint v);
      if (v > SPAN_MAX) return SPAN_MAX;
      if (v < SPAN_MIN) return SPAN_MIN;
      return v;
   endfunction

   // The span counter saturates at 16 bits, and so does each single addition to it.
   function automatic void bump_spans(input longint unsigned n);
      longint unsigned s;
      s = longint'(tm_spans) + ((n > 65535) ? 65535 : n);
      tm_spans = (s > 65535) ? 65535 : int'(s);
   endfunction

   // Continue modes count cycles up or down; the count saturates as a signed 16-bit value.
   function automatic void bump_cycles(input longint unsigned n, input bit down);
      longint c;
      longint v;
      c = (n > 65535) ? 65535 : n;
      v = down ? tm_cycles - c : tm_cycles + c;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      tm_cycles = int'(v);
   endfunction

   // A register write also sets the direction when it selects a play mode.
   function automatic void apply_csr(input logic [1:0] idx, input logic [31:0] wdata);
      case (idx)
         REG_PLAY_MODE: begin
            cf_mode = wdata[2:0];
            tm_back = (cf_mode == MODE_REVERSE || cf_mode == MODE_CONT_REV ||
                       cf_mode == MODE_LOOP_REV);
         end
         REG_SPAN_START: cf_start = $signed(wdata);
         REG_SPAN_END:   cf_end = $signed(wdata);
         REG_SPEED:      cf_speed = $signed(wdata[15:0]);
         default: ;
      endcase
   endfunction

   // Moves the timer by one request and returns the result the block must report for it.
   function automatic result_type next_timer_result(input logic act, input logic [31:0] delta);
      longint unsigned amount, spd, mag, wraps, d, lu, m, r, pos;
      longint          len, t, u, rep;
      bit              neg;
      result_type      res;
      wraps = 0;
      amount = delta;
      len = cf_end - cf_start;
      if (act == ACT_START) begin
         // A start puts the time on the edge that the direction leaves from.
         tm_time = tm_back ? cf_end : cf_start;
         tm_cycles = 0;
         tm_spans = 0;
         tm_run = 1'b1;
      end else if (tm_run && amount != 0) begin
         if (len <= 0) begin
            // An empty or inverted span stops the timer where it is.
            tm_run = 1'b0;
         end else begin
            // The step is the truncated magnitude of delta times speed in Q8.8.
            spd = (cf_speed < 0) ? -cf_speed : cf_speed;
            mag = (amount * spd) >> 8;
            neg = (cf_speed < 0) != tm_back;
            t = neg ? tm_time - longint'(mag) : tm_time + longint'(mag);
            lu = len;
            case (cf_mode)
               MODE_NORMAL: if (t >= cf_end) begin
                  t = cf_end;
                  tm_cycles = 1;
                  bump_spans(1);
                  tm_run = 1'b0;
               end
               MODE_REVERSE: if (t < cf_start) begin
                  t = cf_start;
                  tm_cycles = -1;
                  bump_spans(1);
                  tm_run = 1'b0;
               end
               MODE_CONT, MODE_LOOP: if (t >= cf_end) begin
                  // All wraps of an overshoot are taken in one division.
                  d = t - cf_end;
                  wraps = d / lu + 1;
                  t = cf_start + longint'(d % lu);
                  if (cf_mode == MODE_CONT) bump_cycles(wraps, 1'b0);
                  bump_spans(wraps);
               end
               MODE_CONT_REV, MODE_LOOP_REV: if (t <= cf_start) begin
                  d = cf_start - t;
                  wraps = d / lu + 1;
                  t = cf_end - longint'(d % lu);
                  if (cf_mode == MODE_CONT_REV) bump_cycles(wraps, 1'b1);
                  bump_spans(wraps);
               end
               MODE_PING: begin
                  u = t - cf_start;
                  if (u < 0 || u >= len) begin
                     if (u >= 0) begin
                        m = u;
                        r = m % lu;
                        m = m / lu;
                        if (r != 0) begin
                           wraps = m;
                           pos = m[0] ? lu - r : r;
                        end else begin
                           // Exact landing on an edge: odd m gives the end edge, even the start.
                           wraps = (m == 1) ? 1 : m - 1;
                           pos = m[0] ? lu : 0;
                        end
                     end else begin
                        d = -u;
                        m = d / lu;
                        r = d % lu;
                        if (r != 0) begin
                           wraps = m + 1;
                           pos = m[0] ? lu - r : r;
                        end else begin
                           wraps = m;
                           pos = m[0] ? lu : 0;
                        end
                     end
                     t = cf_start + longint'(pos);
                     if (wraps[0]) tm_back = !tm_back;
                     bump_spans(wraps);
                  end
               end
               default: ; // An unknown mode moves the time with no edge handling.
            endcase
            tm_time = sat32(t);
         end
      end

      // Continue modes report the time unrolled over the counted cycles.
      rep = tm_time;
      if (cf_mode == MODE_CONT || cf_mode == MODE_CONT_REV) rep = tm_time + len * tm_cycles;
      rep = sat32(rep);

      res.time_now        = tm_time[31:0];
      res.reported_time   = rep[31:0];
      res.cycle_count     = tm_cycles[15:0];
      res.spans_completed = tm_spans[15:0];
      res.wraps_in_step   = (wraps > 65535) ? 16'hFFFF : wraps[15:0];
      res.stopped         = !tm_run;
      res.moving_backward = tm_back;
      return res;
   endfunction

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   task automatic push_req(input logic act, input logic [31:0] delta);
      stim_op_t op;
      op = '{is_csr: 1'b0, idx: '0, wdata: '0, act: act, delta: delta,
             gap_pct: gap_set, stall_pct: stall_set};
      stim_q.push_back(op);
   endtask

   task automatic push_csr(input logic [1:0] idx, input logic [31:0] wdata);
      stim_op_t op;
      op = '{is_csr: 1'b1, idx: idx, wdata: wdata, act: 1'b0, delta: '0,
             gap_pct: gap_set, stall_pct: stall_set};
      stim_q.push_back(op);
   endtask

   // Driver. Inputs change only at the falling edge. A request or a register write is held
   // until the monitor has seen its handshake at a rising edge; the next one may follow in
   // the very same cycle. Each signal gets at most one assignment per falling edge.
   // Register writes wait until every predicted result has come back, so the block is idle.
   always @(negedge clock) begin
      stim_op_t op;
      logic     nv_req;
      logic     nv_csr;
      nv_req = req_tvalid;
      nv_csr = csr_valid;
      if (!reset) begin
         if (req_hit) begin
            req_hit = 1'b0;
            nv_req = 1'b0;
         end
         if (csr_hit) begin
            csr_hit = 1'b0;
            nv_csr = 1'b0;
         end
         if (!nv_req && !nv_csr && stim_q.size() != 0) begin
            if (stim_q[0].is_csr) begin
               if (due_results.size() == 0) begin
                  op = stim_q.pop_front();
                  stall_now = op.stall_pct;
                  nv_csr = 1'b1;
                  csr_index <= op.idx;
                  csr_wdata <= op.wdata;
               end
            end else if ($urandom_range(0, 99) >= stim_q[0].gap_pct) begin
               op = stim_q.pop_front();
               stall_now = op.stall_pct;
               nv_req = 1'b1;
               req_tuser <= op.act;
               req_tdata <= op.delta;
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= stall_now);
      end
      req_tvalid <= nv_req;
      csr_valid  <= nv_csr;
   end

   // Monitor. At each rising edge it applies accepted register writes to the predictor,
   // predicts the result of each accepted request, and checks each accepted result against
   // the oldest prediction, field by field.
   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            apply_csr(csr_index, csr_wdata);
            csr_hit = 1'b1;
         end
         if (req_tvalid && req_tready) begin
            due_results.push_back(next_timer_result(req_tuser, req_tdata));
            req_hit = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.time_now        = rsp_tdata[31:0];
            got.reported_time   = rsp_tdata[63:32];
            got.cycle_count     = rsp_tdata[79:64];
            got.spans_completed = rsp_tdata[95:80];
            got.wraps_in_step   = rsp_tdata[111:96];
            got.stopped         = rsp_tdata[112];
            got.moving_backward = rsp_tdata[113];
            if (due_results.size() == 0) begin
               $display("%0t: result with none expected, actual %h", $time, rsp_tdata);
               mismatches++;
            end else begin
               want = due_results.pop_front();
               check_field("time_now", want.time_now, got.time_now);
               check_field("reported_time", want.reported_time, got.reported_time);
               check_field("cycle_count", want.cycle_count, got.cycle_count);
               check_field("spans_completed", want.spans_completed, got.spans_completed);
               check_field("wraps_in_step", want.wraps_in_step, got.wraps_in_step);
               check_field("stopped", want.stopped, got.stopped);
               check_field("moving_backward", want.moving_backward, got.moving_backward);
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      if (!reset) begin
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
         end
      end
   end

   // Stimulus. The queue is filled up front; the driver drains it after reset.
   initial begin
      int         ph;
      int         k;
      int         roll;
      int         start_pct;
      logic [2:0] ph_mode;
      longint     ph_start;
      longint     ph_end;
      longint     ph_speed;
      longint     len;
      longint     spd;
      longint     target;
      longint     amount;

      // Directed part, no idling. Default setup: normal mode over [0, 1.0] at speed 1.0.
      push_req(ACT_ADVANCE, 32'h0001_0000);  // not started yet, nothing moves
      push_req(ACT_START, 32'hFFFF_FFFF);
      push_req(ACT_ADVANCE, 32'h0000_0000);  // a zero step changes nothing
      push_req(ACT_ADVANCE, 32'h0000_8000);
      push_req(ACT_ADVANCE, 32'hFFFF_FFFF);  // clamps at the end and stops
      push_req(ACT_ADVANCE, 32'h0000_0001);  // stopped, ignored

      // Loop mode driven backward by a negative speed: the time runs away from the wrap edge.
      push_csr(REG_PLAY_MODE, 32'(MODE_LOOP));
      push_csr(REG_SPEED, 32'hFFFF_FF80);
      push_req(ACT_START, 32'h0000_0000);
      push_req(ACT_ADVANCE, 32'h0004_0000);

      // Widest span at top speed: a single step overshoots by many spans.
      push_csr(REG_SPAN_START, 32'h8000_0000);
      push_csr(REG_SPAN_END, 32'h7FFF_FFFF);
      push_csr(REG_SPEED, 32'h0000_7FFF);
      push_req(ACT_START, 32'h5555_5555);
      push_req(ACT_ADVANCE, 32'hFFFF_FFFF);

      // Ping-pong over [0, 1.0]: exact landings on both edges, then a long bounce.
      push_csr(REG_PLAY_MODE, 32'(MODE_PING));
      push_csr(REG_SPAN_START, 32'h0000_0000);
      push_csr(REG_SPAN_END, 32'h0001_0000);
      push_csr(REG_SPEED, 32'h0000_0100);
      push_req(ACT_START, 32'hAAAA_AAAA);
      push_req(ACT_ADVANCE, 32'h0002_0000);
      push_req(ACT_ADVANCE, 32'h0001_0000);
      push_req(ACT_ADVANCE, 32'h0001_8000);
      push_req(ACT_ADVANCE, 32'hFFFF_FFFF);

      // Reverse mode over an inverted span: the first advance stops the timer.
      push_csr(REG_PLAY_MODE, 32'(MODE_REVERSE));
      push_csr(REG_SPAN_START, 32'h0001_0000);
      push_csr(REG_SPAN_END, 32'h0000_0000);
      push_req(ACT_START, 32'h0000_0000);
      push_req(ACT_ADVANCE, 32'h0000_0001);

      // The unused mode code moves the time freely until it saturates.
      push_csr(REG_PLAY_MODE, 32'h0000_0007);
      push_csr(REG_SPAN_START, 32'h0000_0000);
      push_csr(REG_SPAN_END, 32'h0001_0000);
      push_csr(REG_SPEED, 32'h0000_7FFF);
      push_req(ACT_START, 32'h0000_0000);
      push_req(ACT_ADVANCE, 32'hFFFF_FFFF);

      // Continue reverse at the most negative speed.
      push_csr(REG_PLAY_MODE, 32'(MODE_CONT_REV));
      push_csr(REG_SPEED, 32'hFFFF_8000);
      push_req(ACT_START, 32'h0000_0000);
      push_req(ACT_ADVANCE, 32'h0001_2345);

      ph_start = 0;
      ph_end = 65536;
      ph_speed = -32768;

      // Random part: twelve phases, each with a new setup and a well-formed run of requests.
      for (ph = 0; ph < 12; ph++) begin
         case (ph % 4)
            0: begin gap_set = 0;  stall_set = 0;  end
            1: begin gap_set = 50; stall_set = 0;  end
            2: begin gap_set = 0;  stall_set = 50; end
            default: begin gap_set = 35; stall_set = 35; end
         endcase

         roll = $urandom_range(0, 13);
         ph_mode = (roll == 13) ? 3'd7 : 3'(roll % 7);
         push_csr(REG_PLAY_MODE, 32'(ph_mode));

         if (ph == 0 || $urandom_range(0, 9) < 6) begin
            case ($urandom_range(0, 9))
               0: begin
                  ph_start = SPAN_MIN;
                  ph_end = SPAN_MAX;
               end
               1: begin
                  // Empty or inverted span.
                  ph_start = longint'($urandom_range(0, 131072)) - 65536;
                  ph_end = ph_start - longint'($urandom_range(0, 65536));
               end
               2: begin
                  ph_end = SPAN_MAX;
                  ph_start = ph_end - longint'($urandom_range(1, 262144));
               end
               3: begin
                  ph_start = SPAN_MIN;
                  ph_end = ph_start + longint'($urandom_range(1, 262144));
               end
               default: begin
                  ph_start = longint'($urandom_range(0, 524288)) - 262144;
                  ph_end = ph_start + longint'($urandom_range(1, 262144));
               end
            endcase
            push_csr(REG_SPAN_START, 32'(ph_start));
            push_csr(REG_SPAN_END, 32'(ph_end));
         end

         if (ph == 0 || $urandom_range(0, 9) < 6) begin
            case ($urandom_range(0, 9))
               0: ph_speed = -32768;
               1: ph_speed = 32767;
               2: ph_speed = 0;
               3: ph_speed = $signed(16'($urandom));
               default: ph_speed = longint'($urandom_range(16, 768)) *
                                   (($urandom_range(0, 3) == 0) ? -1 : 1);
            endcase
            push_csr(REG_SPEED, 32'(ph_speed));
         end

         // Clamping modes stop quickly, so they get restarted more often.
         start_pct = (ph_mode == MODE_NORMAL || ph_mode == MODE_REVERSE) ? 20 : 6;
         len = ph_end - ph_start;
         spd = (ph_speed < 0) ? -ph_speed : ph_speed;

         push_req(ACT_START, $urandom);
         for (k = 1; k < 70; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < start_pct) begin
               push_req(ACT_START, $urandom);
            end else begin
               roll = $urandom_range(0, 99);
               if (roll < 5) begin
                  push_req(ACT_ADVANCE, 32'h0);
               end else if (roll < 17) begin
                  push_req(ACT_ADVANCE, $urandom);
               end else if (roll < 22) begin
                  push_req(ACT_ADVANCE, $urandom_range(1, 255));
               end else if (len <= 0 || len > 16777216 || spd == 0) begin
                  push_req(ACT_ADVANCE, $urandom);
               end else begin
                  // Size the step to move the time by up to three span lengths.
                  target = $urandom_range(0, 32'(3 * len));
                  amount = target * 256 / spd;
                  if (amount > 64'sh0000_0000_FFFF_FFFF) amount = 64'sh0000_0000_FFFF_FFFF;
                  push_req(ACT_ADVANCE, amount[31:0]);
               end
            end
         end
      end

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // Drain: everything sent, every prediction answered, then a quiet tail.
      while (stim_q.size() != 0 || req_tvalid || csr_valid || due_results.size() != 0)
         @(posedge clock);
      repeat (200) @(posedge clock);

      if (mismatches == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule
